@@ sv/pfi_pkg.sv @@
// Shared constants, types and helpers for the particle force integrator.
`default_nettype none
package pfi_pkg;
   localparam int unsigned FracBitsDefault = 16;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 17;

   localparam logic [2:0] ACT_FORCE   = 3'd0;
   localparam logic [2:0] ACT_REPEL   = 3'd1;
   localparam logic [2:0] ACT_ATTRACT = 3'd2;
   localparam logic [2:0] ACT_TICK    = 3'd3;
   localparam logic [2:0] ACT_BOUNCE  = 3'd4;

   localparam logic [CsrIndexWidth-1:0] CSR_DAMPING = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WIDTH   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HEIGHT  = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic [30:0]        radius;
      logic signed [31:0] strength;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic               hit_wall;
   } rsp_word_type;

   // Saturate a 66-bit signed value to the int32 range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) return 32'sh7fffffff;
      else if (v < lo) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage
`default_nettype wire

@@ sv/pfi_stream_if.sv @@
// Valid/ready channel carrying one payload word.
`default_nettype none
interface pfi_stream_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/pfi_divider.sv @@
// Shared restoring divider, also used as a bit-pair square root, one bit a cycle.
`default_nettype none
module pfi_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        sqrt_mode,
   input  wire logic [63:0] numer,
   input  wire logic [63:0] denom,
   output logic             done,
   output logic [63:0]      quot
);
   import pfi_pkg::*;
   logic [63:0] rem_ff, rem_in, num_ff, num_in, q_ff, q_in, den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in, sq_ff, sq_in;
   logic [64:0] trial;
   logic [63:0] shrem;

   always_comb begin
      rem_in = rem_ff; num_in = num_ff; q_in = q_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; sq_in = sq_ff;
      shrem = '0; trial = '0;
      if (start) begin
         rem_in = '0; num_in = numer; q_in = '0; den_in = denom;
         sq_in = sqrt_mode; busy_in = 1'b1;
         cnt_in = sqrt_mode ? 7'd32 : 7'd64;
      end else if (busy_ff) begin
         if (sq_ff) begin
            // Two radicand bits per step; trial subtrahend is 4q+1.
            shrem = {rem_ff[61:0], num_ff[63:62]};
            trial = {1'b0, shrem} - {1'b0, q_ff[61:0], 2'b01};
            num_in = {num_ff[61:0], 2'b00};
         end else begin
            shrem = {rem_ff[62:0], num_ff[63]};
            trial = {1'b0, shrem} - {1'b0, den_ff};
            num_in = {num_ff[62:0], 1'b0};
         end
         if (!trial[64] && !(!sq_ff && rem_ff[63])) begin
            rem_in = trial[63:0]; q_in = {q_ff[62:0], 1'b1};
         end else if (!sq_ff && rem_ff[63]) begin
            rem_in = shrem - den_ff; q_in = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = shrem; q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; num_ff <= num_in; q_ff <= q_in; den_ff <= den_in;
      sq_ff <= sq_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

@@ sv/pfi_core.sv @@
// Sequencer and state registers; one shared multiplier and the shared divider.
`default_nettype none
module pfi_core #(
   parameter int unsigned FRAC_BITS = pfi_pkg::FracBitsDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire pfi_pkg::req_word_type       req_word,
   input  wire logic [16:0]                 damping,
   input  wire logic [12:0]                 screen_width,
   input  wire logic [12:0]                 screen_height,
   output logic                             done,
   output pfi_pkg::rsp_word_type            rsp_word
);
   import pfi_pkg::*;
   localparam logic [4:0] S_IDLE  = 5'd0,  S_DISP  = 5'd1,  S_SQR0 = 5'd2,
                          S_SQR1  = 5'd3,  S_SQRT  = 5'd4,  S_SQRW = 5'd5,
                          S_PCT   = 5'd6,  S_PCTW  = 5'd7,  S_UX   = 5'd8,
                          S_UXW   = 5'd9,  S_UY    = 5'd10, S_UYW  = 5'd11,
                          S_MX0   = 5'd12, S_MX1   = 5'd13, S_MY0  = 5'd14,
                          S_MY1   = 5'd15, S_ACC   = 5'd16, S_TK0  = 5'd17,
                          S_TK1   = 5'd18, S_TK2   = 5'd19, S_BN0  = 5'd20,
                          S_BN1   = 5'd21, S_BN2   = 5'd22, S_DONE = 5'd23;
   localparam logic signed [65:0] One = 66'sd1 <<< FRAC_BITS;
   localparam logic signed [65:0] Mask = One - 66'sd1;
   localparam logic signed [65:0] KBounce = (66'sd3 * One + 66'sd5) / 66'sd10;

   logic [4:0] st_ff, st_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [65:0] dx_ff, dx_in, dy_ff, dy_in, t_ff, t_in, len_ff, len_in;
   logic signed [65:0] pct_ff, pct_in, ux_ff, ux_in, uy_ff, uy_in;
   logic signed [65:0] sq_ff, sq_in;
   logic hit_ff, hit_in, hx_ff, hx_in, neg_ff, neg_in;
   // Every operand fits 34 signed bits: offsets are bounded by the radius first.
   logic signed [33:0] ma, mb;
   logic signed [67:0] prod_full;
   logic signed [65:0] prod, fsh, rad;
   logic dv_start, dv_sqrt, dv_done;
   logic [63:0] dv_num, dv_den, dv_q;
   logic signed [65:0] wall_max;

   pfi_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .sqrt_mode(dv_sqrt),
      .numer(dv_num), .denom(dv_den), .done(dv_done), .quot(dv_q)
   );

   // The one shared multiplier followed by floor scaling.
   assign prod_full = ma * mb;
   assign prod = prod_full[65:0];
   assign fsh = (prod >= 0) ? (prod >>> FRAC_BITS) : -(((-prod) + Mask) >>> FRAC_BITS);
   assign rad = {35'd0, req_word.radius};

   always_comb begin
      st_in = st_ff; px_in = px_ff; py_in = py_ff; vx_in = vx_ff; vy_in = vy_ff;
      ax_in = ax_ff; ay_in = ay_ff; dx_in = dx_ff; dy_in = dy_ff; t_in = t_ff;
      len_in = len_ff; pct_in = pct_ff; ux_in = ux_ff; uy_in = uy_ff; sq_in = sq_ff;
      hit_in = hit_ff; hx_in = hx_ff; neg_in = neg_ff;
      ma = '0; mb = '0; dv_start = 1'b0; dv_sqrt = 1'b0; dv_num = '0; dv_den = '0;
      wall_max = '0;
      unique case (st_ff)
         S_IDLE: if (start) begin
            st_in = S_DISP; hit_in = 1'b0;
         end
         S_DISP: begin
            dx_in = 66'(px_ff) - 66'(req_word.vec_x);
            dy_in = 66'(py_ff) - 66'(req_word.vec_y);
            neg_in = (req_word.action == ACT_ATTRACT);
            priority case (req_word.action)
               ACT_FORCE: begin
                  ax_in = sat32(66'(ax_ff) + 66'(req_word.vec_x));
                  ay_in = sat32(66'(ay_ff) + 66'(req_word.vec_y));
                  st_in = S_DONE;
               end
               ACT_REPEL, ACT_ATTRACT: st_in = S_SQR0;
               ACT_TICK: st_in = S_TK0;
               ACT_BOUNCE: st_in = S_BN0;
               default: st_in = S_DONE;
            endcase
         end
         S_SQR0: begin
            if (rad == 0 || (dx_ff < 0 ? -dx_ff : dx_ff) > rad ||
                (dy_ff < 0 ? -dy_ff : dy_ff) > rad) st_in = S_DONE;
            else begin
               ma = dx_ff[33:0]; mb = dx_ff[33:0]; sq_in = prod; st_in = S_SQR1;
            end
         end
         S_SQR1: begin
            ma = dy_ff[33:0]; mb = dy_ff[33:0]; sq_in = sq_ff + prod; st_in = S_SQRT;
         end
         S_SQRT: begin
            dv_start = 1'b1; dv_sqrt = 1'b1; dv_num = sq_ff[63:0]; st_in = S_SQRW;
         end
         S_SQRW: if (dv_done) begin
            len_in = {2'b00, dv_q};
            if ({2'b00, dv_q} > rad || dv_q == 0) st_in = S_DONE;
            else st_in = S_PCT;
         end
         S_PCT: begin
            dv_start = 1'b1; dv_num = 64'((rad - len_ff) <<< FRAC_BITS);
            dv_den = rad[63:0]; st_in = S_PCTW;
         end
         S_PCTW: if (dv_done) begin
            pct_in = {2'b00, dv_q}; st_in = S_UX;
         end
         S_UX: begin
            dv_start = 1'b1;
            dv_num = 64'(((dx_ff < 0) ? -dx_ff : dx_ff) <<< FRAC_BITS);
            dv_den = len_ff[63:0]; st_in = S_UXW;
         end
         S_UXW: if (dv_done) begin
            ux_in = (dx_ff < 0) ? -$signed({2'b00, dv_q}) : $signed({2'b00, dv_q});
            st_in = S_UY;
         end
         S_UY: begin
            dv_start = 1'b1;
            dv_num = 64'(((dy_ff < 0) ? -dy_ff : dy_ff) <<< FRAC_BITS);
            dv_den = len_ff[63:0]; st_in = S_UYW;
         end
         S_UYW: if (dv_done) begin
            uy_in = (dy_ff < 0) ? -$signed({2'b00, dv_q}) : $signed({2'b00, dv_q});
            st_in = S_MX0;
         end
         S_MX0: begin
            ma = ux_ff[33:0]; mb = 34'(req_word.strength); t_in = fsh; st_in = S_MX1;
         end
         S_MX1: begin
            ma = t_ff[33:0]; mb = pct_ff[33:0]; ux_in = neg_ff ? -fsh : fsh;
            st_in = S_MY0;
         end
         S_MY0: begin
            ma = uy_ff[33:0]; mb = 34'(req_word.strength); t_in = fsh; st_in = S_MY1;
         end
         S_MY1: begin
            ma = t_ff[33:0]; mb = pct_ff[33:0]; uy_in = neg_ff ? -fsh : fsh;
            st_in = S_ACC;
         end
         S_ACC: begin
            ax_in = sat32(66'(ax_ff) + ux_ff);
            ay_in = sat32(66'(ay_ff) + uy_ff);
            st_in = S_DONE;
         end
         S_TK0: begin
            // Keep factor: one minus the clamped damping in this format.
            t_in = One - (((damping > 17'd65536) ? 66'sd65536 : 66'($unsigned(damping)))
                   <<< FRAC_BITS >>> 16);
            ux_in = 66'(sat32(66'(vx_ff) + 66'(ax_ff)));
            uy_in = 66'(sat32(66'(vy_ff) + 66'(ay_ff)));
            st_in = S_TK1;
         end
         S_TK1: begin
            ma = ux_ff[33:0]; mb = t_ff[33:0]; vx_in = sat32(fsh); st_in = S_TK2;
         end
         S_TK2: begin
            ma = uy_ff[33:0]; mb = t_ff[33:0]; vy_in = sat32(fsh);
            px_in = sat32(66'(px_ff) + 66'(vx_ff));
            py_in = sat32(66'(py_ff) + 66'(sat32(fsh)));
            ax_in = '0; ay_in = '0; st_in = S_DONE;
         end
         S_BN0: begin
            wall_max = 66'(sat32(66'($unsigned(screen_width)) <<< FRAC_BITS));
            hx_in = 1'b1;
            if (66'(px_ff) > wall_max) px_in = wall_max[31:0];
            else if (px_ff < 0) px_in = '0;
            else hx_in = 1'b0;
            if (hx_in) vx_in = sat32(-66'(vx_ff));
            st_in = S_BN1;
         end
         S_BN1: begin
            wall_max = 66'(sat32(66'($unsigned(screen_height)) <<< FRAC_BITS));
            hit_in = 1'b1;
            if (66'(py_ff) > wall_max) py_in = wall_max[31:0];
            else if (py_ff < 0) py_in = '0;
            else hit_in = 1'b0;
            if (hit_in) vy_in = sat32(-66'(vy_ff));
            hit_in = hit_in | hx_ff;
            st_in = hit_in ? S_BN2 : S_DONE;
         end
         S_BN2: begin
            ma = 34'(vx_ff); mb = KBounce[33:0]; vx_in = sat32(fsh);
            ux_in = 66'(vy_ff); st_in = S_DONE;
            // The y product uses the multiplier on the next cycle.
            neg_in = 1'b1;
         end
         S_DONE: begin
            if (neg_ff && req_word.action == ACT_BOUNCE && hit_ff) begin
               ma = ux_ff[33:0]; mb = KBounce[33:0]; vy_in = sat32(fsh); neg_in = 1'b0;
            end
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in; dy_ff <= dy_in; t_ff <= t_in; len_ff <= len_in;
      pct_ff <= pct_in; ux_ff <= ux_in; uy_ff <= uy_in; sq_ff <= sq_in;
      hx_ff <= hx_in; neg_ff <= neg_in;
      if (reset) begin
         st_ff <= S_IDLE; hit_ff <= 1'b0;
         px_ff <= sat32(66'sd512 <<< FRAC_BITS);
         py_ff <= sat32(66'sd384 <<< FRAC_BITS);
         vx_ff <= '0; vy_ff <= '0; ax_ff <= '0; ay_ff <= '0;
      end else begin
         st_ff <= st_in; hit_ff <= hit_in;
         px_ff <= px_in; py_ff <= py_in; vx_ff <= vx_in; vy_ff <= vy_in;
         ax_ff <= ax_in; ay_ff <= ay_in;
      end
   end

   assign done = (st_ff == S_DONE);
   assign rsp_word.pos_x = px_in;
   assign rsp_word.pos_y = py_in;
   assign rsp_word.vel_x = vx_in;
   assign rsp_word.vel_y = vy_in;
   assign rsp_word.hit_wall = hit_ff;
endmodule
`default_nettype wire

@@ sv/particle_force_integrator.sv @@
// Top level of the particle force integrator.
//   channel | direction | word
//   req     | in        | action, vec_x, vec_y, radius, strength
//   rsp     | out       | pos_x, pos_y, vel_x, vel_y, hit_wall
//   csr     | in        | write enable, index, data
// A result word is registered once the core reaches its done state; add force and unused
// actions go there from dispatch, tick after its update states, bounce after its wall
// states plus one more on a hit. Repel and attract can take longest, as the shared
// one-bit-a-cycle divider runs a 32-step square root and three 64-step divisions in turn.
// Reset is synchronous and restores the particle and the registers. The request side is
// not ready while a word is worked on or a result waits in the output register to be taken.
`default_nettype none
module particle_force_integrator #(
   parameter int unsigned FRAC_BITS = pfi_pkg::FracBitsDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   pfi_stream_if.sink                              req,
   pfi_stream_if.source                            rsp,
   input  wire logic                               csr_write_enable,
   input  wire logic [pfi_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [pfi_pkg::CsrDataWidth-1:0]   csr_write_data
);
   import pfi_pkg::*;
   logic [16:0] damping_ff;
   logic [12:0] width_ff, height_ff;
   logic busy_ff, rv_ff, done;
   req_word_type word_ff;
   rsp_word_type core_rsp, out_ff;

   pfi_core #(.FRAC_BITS(FRAC_BITS)) u_core (
      .clock(clock), .reset(reset), .start(req.valid && req.ready),
      .req_word(word_ff), .damping(damping_ff), .screen_width(width_ff),
      .screen_height(height_ff), .done(done), .rsp_word(core_rsp)
   );

   assign req.ready = !busy_ff && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= 17'd19661; width_ff <= 13'd1024; height_ff <= 13'd768;
         busy_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            priority case (csr_index)
               CSR_DAMPING: damping_ff <= csr_write_data;
               CSR_WIDTH:   width_ff <= csr_write_data[12:0];
               CSR_HEIGHT:  height_ff <= csr_write_data[12:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) busy_ff <= 1'b1;
         else if (done) busy_ff <= 1'b0;
         if (done) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
      end
      // The accepted word is held here for the whole computation.
      if (req.valid && req.ready) word_ff <= req.payload;
      if (done) out_ff <= core_rsp;
   end
endmodule
`default_nettype wire

@@ sv/pfi_checker.sv @@
// Port-level checker for the particle force integrator, bound to the top level.
`default_nettype none
module pfi_port_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic hit_wall
);
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while a word waits");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_wall))
      else $error("result word dropped or changed");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready right after accept");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result valid after reset");
   a_hit_only_valid: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready)) else $error("result without work");
endmodule

bind particle_force_integrator pfi_port_checker u_pfi_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .hit_wall(rsp.payload.hit_wall)
);
`default_nettype wire

@@ sim/pfi_checker.sv @@
// Watches the request and response channels, predicts each response and compares it.
`default_nettype none
module pfi_checker
   import pfi_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire req_word_type req_word,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire rsp_word_type rsp_word,
   input  wire logic         csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data,
   output int                failures,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Frac = 16;

   int unsigned damp_setting;
   int unsigned wall_x;
   int unsigned wall_y;
   int pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
   rsp_word_type expected_words[$];

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void apply_radial(longint px, longint py, longint rad, longint str,
                                        bit pull);
      longint dx, dy, len, pct, ux, uy, fx, fy;
      dx = longint'(pos_x) - px;
      dy = longint'(pos_y) - py;
      if (rad == 0) return;
      if ((dx < 0 ? -dx : dx) > rad || (dy < 0 ? -dy : dy) > rad) return;
      len = longint'(int_sqrt(longint'(dx * dx) + longint'(dy * dy)));
      if (len > rad || len == 0) return;
      pct = ((rad - len) * (64'sd1 << Frac)) / rad;
      ux = (dx * (64'sd1 << Frac)) / len;
      uy = (dy * (64'sd1 << Frac)) / len;
      fx = (((ux * str) >>> Frac) * pct) >>> Frac;
      fy = (((uy * str) >>> Frac) * pct) >>> Frac;
      if (pull) begin
         fx = -fx;
         fy = -fy;
      end
      acc_x = clamp32(longint'(acc_x) + fx);
      acc_y = clamp32(longint'(acc_y) + fy);
   endfunction

   // Clamps one coordinate into [0, size << Frac] and reflects its velocity on a hit.
   function automatic bit clamp_wall(ref int p, ref int v, input int unsigned size);
      int lim;
      lim = clamp32(longint'(size) << Frac);
      if (p > lim) p = lim;
      else if (p < 0) p = 0;
      else return 1'b0;
      v = clamp32(-longint'(v));
      return 1'b1;
   endfunction

   function automatic rsp_word_type integrate_word(req_word_type w);
      rsp_word_type r;
      longint keep, vx, vy, d;
      bit hx, hy, hit;
      longint bounce_gain;
      hit = 1'b0;
      bounce_gain = (64'sd3 * (64'sd1 << Frac) + 5) / 10;
      case (w.action)
         ACT_FORCE: begin
            acc_x = clamp32(longint'(acc_x) + longint'(w.vec_x));
            acc_y = clamp32(longint'(acc_y) + longint'(w.vec_y));
         end
         ACT_REPEL, ACT_ATTRACT:
            apply_radial(longint'(w.vec_x), longint'(w.vec_y), longint'({33'd0, w.radius}),
                         longint'(w.strength), w.action == ACT_ATTRACT);
         ACT_TICK: begin
            d = damp_setting > 65536 ? 65536 : damp_setting;
            keep = (64'sd1 << Frac) - ((d << Frac) >> 16);
            vx = clamp32(longint'(vel_x) + acc_x);
            vy = clamp32(longint'(vel_y) + acc_y);
            vel_x = clamp32((vx * keep) >>> Frac);
            vel_y = clamp32((vy * keep) >>> Frac);
            pos_x = clamp32(longint'(pos_x) + vel_x);
            pos_y = clamp32(longint'(pos_y) + vel_y);
            acc_x = 0;
            acc_y = 0;
         end
         ACT_BOUNCE: begin
            hx = clamp_wall(pos_x, vel_x, wall_x);
            hy = clamp_wall(pos_y, vel_y, wall_y);
            if (hx || hy) begin
               vel_x = clamp32((longint'(vel_x) * bounce_gain) >>> Frac);
               vel_y = clamp32((longint'(vel_y) * bounce_gain) >>> Frac);
               hit = 1'b1;
            end
         end
         default: ;
      endcase
      r.pos_x = pos_x;
      r.pos_y = pos_y;
      r.vel_x = vel_x;
      r.vel_y = vel_y;
      r.hit_wall = hit;
      return r;
   endfunction

   initial failures = 0;
   assign pending = expected_words.size();

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         damp_setting = 19661;
         wall_x = 1024;
         wall_y = 768;
         pos_x = 512 << Frac;
         pos_y = 384 << Frac;
         vel_x = 0;
         vel_y = 0;
         acc_x = 0;
         acc_y = 0;
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DAMPING: damp_setting = csr_write_data;
               CSR_WIDTH:   wall_x = csr_write_data[12:0];
               CSR_HEIGHT:  wall_y = csr_write_data[12:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_words.push_back(integrate_word(req_word));
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with no expectation waiting");
               failures++;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_word.pos_x !== exp_w.pos_x) begin
                  $error("pos_x expected %0d actual %0d", exp_w.pos_x, rsp_word.pos_x);
                  failures++;
               end
               if (rsp_word.pos_y !== exp_w.pos_y) begin
                  $error("pos_y expected %0d actual %0d", exp_w.pos_y, rsp_word.pos_y);
                  failures++;
               end
               if (rsp_word.vel_x !== exp_w.vel_x) begin
                  $error("vel_x expected %0d actual %0d", exp_w.vel_x, rsp_word.vel_x);
                  failures++;
               end
               if (rsp_word.vel_y !== exp_w.vel_y) begin
                  $error("vel_y expected %0d actual %0d", exp_w.vel_y, rsp_word.vel_y);
                  failures++;
               end
               if (rsp_word.hit_wall !== exp_w.hit_wall) begin
                  $error("hit_wall expected %0d actual %0d", exp_w.hit_wall,
                         rsp_word.hit_wall);
                  failures++;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Stimulus, clock, reset and verdict for the particle force integrator.
`default_nettype none
module tb_top;
   import pfi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 3000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;
   int failures;
   int pending;
   int rsp_count;
   int idle_cycles;
   int last_px, last_py;

   pfi_stream_if #(.payload_type(req_word_type)) req_ch (clock);
   pfi_stream_if #(.payload_type(rsp_word_type)) rsp_ch (clock);

   particle_force_integrator dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   pfi_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_word(req_ch.payload),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_word(rsp_ch.payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Track the latest reported position so that radial sources land near the particle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_count <= 0;
         last_px <= 512 << 16;
         last_py <= 384 << 16;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_count <= rsp_count + 1;
         last_px <= rsp_ch.payload.pos_x;
         last_py <= rsp_ch.payload.pos_y;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: stall modes are picked at random in turn, plus one long hold-off.
   initial begin
      int mode;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && rsp_count >= 500) begin
            held = 1'b1;
            rsp_ch.ready = 1'b0;
            repeat (500) @(negedge clock);
         end
         mode = $urandom_range(0, 2);
         repeat (64) begin
            case (mode)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = $urandom_range(0, 1);
               default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic put_word(req_word_type w);
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.payload = w;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_sender(int n);
      @(negedge clock);
      req_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value[CsrDataWidth-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // A radial work word aimed close to the last known position.
   function automatic req_word_type near_radial(logic [2:0] act);
      req_word_type w;
      longint rad, ox, oy;
      w.action = act;
      rad = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(1, 32'h7fffffff))
                                        : longint'($urandom_range(1, 300 << 16));
      ox = longint'($urandom_range(0, 32'hffffffff) % (rad + 1)) - rad / 2;
      oy = longint'($urandom_range(0, 32'hffffffff) % (rad + 1)) - rad / 2;
      ox = ox + last_px;
      oy = oy + last_py;
      w.vec_x = ox > 64'sd2147483647 ? 32'sh7fffffff :
                ox < -64'sd2147483648 ? 32'sh80000000 : int'(ox);
      w.vec_y = oy > 64'sd2147483647 ? 32'sh7fffffff :
                oy < -64'sd2147483648 ? 32'sh80000000 : int'(oy);
      w.radius = rad[30:0];
      w.strength = ($urandom_range(0, 3) == 0) ? $urandom
                                               : int'($urandom_range(0, 40 << 16)) - (20 << 16);
      return w;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w.vec_x = $urandom;
      w.vec_y = $urandom;
      w.radius = $urandom;
      w.strength = $urandom;
      if (pick < 25) begin
         w.action = ACT_FORCE;
         if (pick < 20) begin
            w.vec_x = int'($urandom_range(0, 8 << 16)) - (4 << 16);
            w.vec_y = int'($urandom_range(0, 8 << 16)) - (4 << 16);
         end
      end else if (pick < 55) begin
         w = near_radial(pick < 40 ? ACT_REPEL : ACT_ATTRACT);
      end else if (pick < 80) begin
         w.action = ACT_TICK;
      end else if (pick < 94) begin
         w.action = ACT_BOUNCE;
      end else begin
         w.action = $urandom_range(0, 7);
      end
      return w;
   endfunction

   task automatic send_random(int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && sent < count) begin
            put_word(random_word());
            sent++;
            burst--;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 30));
      end
   endtask

   // Lets the block drain before registers change.
   task automatic wait_drained();
      idle_sender(1);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_directed();
      req_word_type w;
      w = '0;
      w.action = ACT_REPEL;
      w.vec_x = 512 << 16;
      w.vec_y = 384 << 16;
      w.radius = 10 << 16;
      w.strength = 1 << 16;
      put_word(w);                  // distance zero gives no force
      w.vec_x = (512 << 16) - (3 << 16);
      w.radius = 0;
      put_word(w);                  // zero radius changes nothing
      w.radius = 2 << 16;
      put_word(w);                  // x offset beyond the radius
      w.radius = 31'h7fffffff;
      w.strength = 32'sh7fffffff;
      put_word(w);
      w.action = ACT_ATTRACT;
      w.strength = 32'sh80000000;
      w.radius = 5 << 16;
      w.vec_y = (384 << 16) + (2 << 16);
      put_word(w);
      w.radius = 1;
      put_word(w);
      w = '0;
      w.action = ACT_BOUNCE;
      put_word(w);
      w.action = ACT_TICK;
      put_word(w);
      w.action = ACT_FORCE;
      w.vec_x = 32'sh7fffffff;
      w.vec_y = 32'sh80000000;
      put_word(w);
      put_word(w);                  // accumulator saturates
      w.action = ACT_TICK;
      put_word(w);
      put_word(w);
      w.action = ACT_BOUNCE;
      put_word(w);
      w.action = ACT_FORCE;
      w.vec_x = 32'sh80000000;
      w.vec_y = 32'sh7fffffff;
      put_word(w);
      put_word(w);
      w.action = ACT_TICK;
      put_word(w);
      w.action = ACT_BOUNCE;
      put_word(w);
      put_word(w);
      for (int a = 5; a < 8; a++) begin
         w.action = a;
         w.vec_x = $urandom;
         w.radius = $urandom;
         put_word(w);
      end
   endtask

   initial begin
      int unsigned damp_list[5];
      int unsigned width_list[5];
      int unsigned height_list[5];
      damp_list = '{19661, 0, 65536, 131071, 0};
      width_list = '{1024, 1, 4096, 0, 0};
      height_list = '{768, 1, 4096, 8191, 0};
      damp_list[4] = $urandom_range(0, 65536);
      width_list[4] = $urandom_range(1, 4096);
      height_list[4] = $urandom_range(1, 4096);
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_DAMPING;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_directed();
      wait_drained();
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_DAMPING, damp_list[p]);
         write_reg(CSR_WIDTH, width_list[p]);
         write_reg(CSR_HEIGHT, height_list[p]);
         send_random(275);
         wait_drained();
      end
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/pfi_pkg.sv
sv/pfi_stream_if.sv
sv/pfi_divider.sv
sv/pfi_core.sv
sv/particle_force_integrator.sv
sv/pfi_checker.sv
sim/pfi_checker.sv
sim/tb_top.sv
